/* rtl/char_lcd_parallel_sequencer_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD sequencer
// Implication checks on a clock with an active-low reset; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_PARALLEL_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_PARALLEL_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH
`define CLCD_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clcd check failed");
`define CLCD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clcd check failed");
`else
`define CLCD_ASSERT_NOW(lbl, ck, rst_n, ante, cons)
`define CLCD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

/* rtl/clcd_seq_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_seq_pkg
// Types, codes and constants shared by the character LCD sequencer.
// ----------------------------------------------------------------------------
package clcd_seq_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = 6;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [7:0] POS_CMD_BASE = 8'd128;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;

	localparam logic [2:0] REG_BUS_FOUR_BIT  = 3'd0;
	localparam logic [2:0] REG_FIRST_FS      = 3'd1;
	localparam logic [2:0] REG_FUNCTION_SET  = 3'd2;
	localparam logic [2:0] REG_DISPLAY_CTRL  = 3'd3;
	localparam logic [2:0] REG_CLEAR         = 3'd4;
	localparam logic [2:0] REG_ENTRY_MODE    = 3'd5;
	localparam logic [2:0] REG_HOME_ADDRESS  = 3'd6;

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_START = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_CLEAR = 3'd3,
		ACT_LOAD  = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_ROW_ERR   = 2'd2,
		ST_COL_ERR   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_INIT = 2'd1,
		MODE_OPER = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		INIT_ARM   = 3'd0,
		INIT_FS1   = 3'd1,
		INIT_FS2   = 3'd2,
		INIT_DISP  = 3'd3,
		INIT_CLR   = 3'd4,
		INIT_ENTRY = 3'd5,
		INIT_HOME  = 3'd6,
		INIT_DONE  = 3'd7
	} init_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		RSTEP_START = 2'd0,
		RSTEP_CMD   = 2'd1,
		RSTEP_DATA  = 2'd2,
		RSTEP_END   = 2'd3
	} rstep_t;

	typedef struct packed {
		logic       bus_four_bit;
		logic [7:0] first_function_set;
		logic [7:0] function_set_cmd;
		logic [7:0] display_ctrl_cmd;
		logic [7:0] clear_cmd;
		logic [7:0] entry_mode_cmd;
		logic [7:0] home_address_cmd;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       action;
		logic [1:0]       row;
		logic [4:0]       column;
		logic [LEN_W-1:0] length;
		logic [4:0]       char_index;
		logic [7:0]       char_code;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic       busy;
		logic       ready;
		logic       rs;
		logic       en;
		logic [7:0] data;
	} res_t;

endpackage

/* rtl/clcd_seq_regs.sv */
// ----------------------------------------------------------------------------
// clcd_seq_regs
// APB-style configuration registers for the character LCD sequencer.
// ----------------------------------------------------------------------------
module clcd_seq_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [clcd_seq_pkg::ADDR_W-1:0]  paddr,
	input  logic [clcd_seq_pkg::DATA_W-1:0]  pwdata,
	output logic [clcd_seq_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output clcd_seq_pkg::cfg_t               cfg
);

	localparam int ADDR_W_HI = clcd_seq_pkg::ADDR_W - 1;

	clcd_seq_pkg::cfg_t cfg_q;
	logic               wr_en;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W_HI:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_four_bit       <= 1'b0;
			cfg_q.first_function_set <= 8'd50;
			cfg_q.function_set_cmd   <= 8'd56;
			cfg_q.display_ctrl_cmd   <= 8'd12;
			cfg_q.clear_cmd          <= 8'd1;
			cfg_q.entry_mode_cmd     <= 8'd6;
			cfg_q.home_address_cmd   <= 8'd128;
		end else if (wr_en) begin
			unique case (reg_idx)
				clcd_seq_pkg::REG_BUS_FOUR_BIT: cfg_q.bus_four_bit       <= pwdata[0];
				clcd_seq_pkg::REG_FIRST_FS:     cfg_q.first_function_set <= pwdata[7:0];
				clcd_seq_pkg::REG_FUNCTION_SET: cfg_q.function_set_cmd   <= pwdata[7:0];
				clcd_seq_pkg::REG_DISPLAY_CTRL: cfg_q.display_ctrl_cmd   <= pwdata[7:0];
				clcd_seq_pkg::REG_CLEAR:        cfg_q.clear_cmd          <= pwdata[7:0];
				clcd_seq_pkg::REG_ENTRY_MODE:   cfg_q.entry_mode_cmd     <= pwdata[7:0];
				clcd_seq_pkg::REG_HOME_ADDRESS: cfg_q.home_address_cmd   <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			clcd_seq_pkg::REG_BUS_FOUR_BIT: prdata = 32'(cfg_q.bus_four_bit);
			clcd_seq_pkg::REG_FIRST_FS:     prdata = 32'(cfg_q.first_function_set);
			clcd_seq_pkg::REG_FUNCTION_SET: prdata = 32'(cfg_q.function_set_cmd);
			clcd_seq_pkg::REG_DISPLAY_CTRL: prdata = 32'(cfg_q.display_ctrl_cmd);
			clcd_seq_pkg::REG_CLEAR:        prdata = 32'(cfg_q.clear_cmd);
			clcd_seq_pkg::REG_ENTRY_MODE:   prdata = 32'(cfg_q.entry_mode_cmd);
			clcd_seq_pkg::REG_HOME_ADDRESS: prdata = 32'(cfg_q.home_address_cmd);
			default:                        prdata = '0;
		endcase
	end

endmodule

/* rtl/clcd_seq_engine.sv */
// ----------------------------------------------------------------------------
// clcd_seq_engine
// Sequencer state, character buffer and the per-word next-state logic.
// ----------------------------------------------------------------------------
module clcd_seq_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  clcd_seq_pkg::item_t   item,
	input  clcd_seq_pkg::cfg_t    cfg,
	output clcd_seq_pkg::res_t    res
);

	localparam int AW = clcd_seq_pkg::BUF_AW;
	localparam int LW = clcd_seq_pkg::LEN_W;

	clcd_seq_pkg::mode_t  mode_q,  mode_n;
	clcd_seq_pkg::init_t  init_q,  init_n;
	clcd_seq_pkg::req_t   req_q,   req_n;
	clcd_seq_pkg::rstep_t rstep_q, rstep_n;
	logic                 en_q,    en_n;
	logic                 hin_q,   hin_n;
	logic [LW-1:0]        left_q,  left_n;
	logic [LW-1:0]        wlen_q,  wlen_n;
	logic                 row_q,   row_n;
	logic [3:0]           col_q,   col_n;
	logic                 rs_q,    rs_n;
	logic [7:0]           data_q,  data_n;
	clcd_seq_pkg::status_t status_n;

	logic [7:0]    store_q [clcd_seq_pkg::BUF_DEPTH];
	logic          st_we;
	logic [LW-1:0] rd_idx;
	logic [7:0]    rd_byte;
	logic [7:0]    pos_byte;
	logic          phase_end;
	logic          do_ph;
	logic [7:0]    ph_byte;
	logic          ph_rs;
	logic          free_now;
	logic [LW-1:0] len_clamped;

	assign rd_idx    = wlen_q - left_q;
	assign rd_byte   = (rd_idx < LW'(clcd_seq_pkg::BUF_DEPTH)) ? store_q[rd_idx[AW-1:0]] : 8'd0;
	assign pos_byte  = clcd_seq_pkg::POS_CMD_BASE | (row_q ? clcd_seq_pkg::ROW1_OFFSET : 8'd0)
		| {4'd0, col_q};
	assign phase_end = en_q && (!cfg.bus_four_bit || hin_q);
	assign free_now  = (mode_q == clcd_seq_pkg::MODE_OPER) && (req_q == clcd_seq_pkg::REQ_NONE);
	assign len_clamped = (item.length > LW'(clcd_seq_pkg::BUF_DEPTH)) ?
		LW'(clcd_seq_pkg::BUF_DEPTH) : item.length;
	assign st_we = fire && (clcd_seq_pkg::act_t'(item.action) == clcd_seq_pkg::ACT_LOAD)
		&& (32'(item.char_index) < clcd_seq_pkg::BUF_DEPTH);

	always_comb begin
		mode_n   = mode_q;
		init_n   = init_q;
		req_n    = req_q;
		rstep_n  = rstep_q;
		en_n     = en_q;
		hin_n    = hin_q;
		left_n   = left_q;
		wlen_n   = wlen_q;
		row_n    = row_q;
		col_n    = col_q;
		rs_n     = rs_q;
		data_n   = data_q;
		status_n = clcd_seq_pkg::ST_OK;
		do_ph    = 1'b0;
		ph_byte  = 8'd0;
		ph_rs    = 1'b0;

		unique case (clcd_seq_pkg::act_t'(item.action))
			clcd_seq_pkg::ACT_TICK: begin
				if (mode_q == clcd_seq_pkg::MODE_INIT) begin
					unique case (init_q)
						clcd_seq_pkg::INIT_ARM: begin
							en_n   = 1'b0;
							init_n = clcd_seq_pkg::INIT_FS1;
						end
						clcd_seq_pkg::INIT_DONE: mode_n = clcd_seq_pkg::MODE_OPER;
						default: begin
							do_ph = 1'b1;
							unique case (init_q)
								clcd_seq_pkg::INIT_FS1: ph_byte = cfg.bus_four_bit ?
									cfg.first_function_set : cfg.function_set_cmd;
								clcd_seq_pkg::INIT_FS2:   ph_byte = cfg.function_set_cmd;
								clcd_seq_pkg::INIT_DISP:  ph_byte = cfg.display_ctrl_cmd;
								clcd_seq_pkg::INIT_CLR:   ph_byte = cfg.clear_cmd;
								clcd_seq_pkg::INIT_ENTRY: ph_byte = cfg.entry_mode_cmd;
								default:                  ph_byte = cfg.home_address_cmd;
							endcase
							if (phase_end) begin
								if (init_q == clcd_seq_pkg::INIT_FS1 && !cfg.bus_four_bit)
									init_n = clcd_seq_pkg::INIT_DISP;
								else
									init_n = clcd_seq_pkg::init_t'(init_q + 3'd1);
							end
						end
					endcase
				end else if (mode_q == clcd_seq_pkg::MODE_OPER
					&& req_q == clcd_seq_pkg::REQ_WRITE) begin
					unique case (rstep_q)
						clcd_seq_pkg::RSTEP_START: begin
							en_n    = 1'b0;
							rstep_n = clcd_seq_pkg::RSTEP_CMD;
						end
						clcd_seq_pkg::RSTEP_CMD: begin
							do_ph   = 1'b1;
							ph_byte = pos_byte;
							if (phase_end)
								rstep_n = clcd_seq_pkg::RSTEP_DATA;
						end
						clcd_seq_pkg::RSTEP_DATA: begin
							if (left_q == '0) begin
								rstep_n = clcd_seq_pkg::RSTEP_END;
								en_n    = 1'b0;
							end else if (en_q) begin
								en_n = 1'b0;
								if (!cfg.bus_four_bit)
									left_n = left_q - LW'(1);
							end else begin
								do_ph   = 1'b1;
								ph_byte = rd_byte;
								ph_rs   = 1'b1;
								if (cfg.bus_four_bit && !hin_q)
									left_n = left_q - LW'(1);
							end
						end
						default: begin
							req_n   = clcd_seq_pkg::REQ_NONE;
							rstep_n = clcd_seq_pkg::RSTEP_START;
						end
					endcase
				end else if (mode_q == clcd_seq_pkg::MODE_OPER
					&& req_q == clcd_seq_pkg::REQ_CLEAR) begin
					unique case (rstep_q)
						clcd_seq_pkg::RSTEP_START: begin
							en_n    = 1'b0;
							rstep_n = clcd_seq_pkg::RSTEP_CMD;
						end
						clcd_seq_pkg::RSTEP_CMD: begin
							do_ph   = 1'b1;
							ph_byte = cfg.clear_cmd;
							if (phase_end)
								rstep_n = clcd_seq_pkg::RSTEP_DATA;
						end
						default: begin
							req_n   = clcd_seq_pkg::REQ_NONE;
							rstep_n = clcd_seq_pkg::RSTEP_START;
						end
					endcase
				end
			end
			clcd_seq_pkg::ACT_START: begin
				mode_n  = clcd_seq_pkg::MODE_INIT;
				init_n  = clcd_seq_pkg::INIT_ARM;
				req_n   = clcd_seq_pkg::REQ_NONE;
				rstep_n = clcd_seq_pkg::RSTEP_START;
				en_n    = 1'b0;
				hin_n   = 1'b1;
			end
			clcd_seq_pkg::ACT_WRITE: begin
				priority if (item.row > 2'd1) begin
					status_n = clcd_seq_pkg::ST_ROW_ERR;
				end else if (item.column > 5'd15) begin
					status_n = clcd_seq_pkg::ST_COL_ERR;
				end else if (!free_now) begin
					status_n = clcd_seq_pkg::ST_NOT_READY;
				end else begin
					row_n   = item.row[0];
					col_n   = item.column[3:0];
					wlen_n  = len_clamped;
					left_n  = len_clamped;
					req_n   = clcd_seq_pkg::REQ_WRITE;
					rstep_n = clcd_seq_pkg::RSTEP_START;
				end
			end
			clcd_seq_pkg::ACT_CLEAR: begin
				if (!free_now) begin
					status_n = clcd_seq_pkg::ST_NOT_READY;
				end else begin
					req_n   = clcd_seq_pkg::REQ_CLEAR;
					rstep_n = clcd_seq_pkg::RSTEP_START;
				end
			end
			default: begin
			end
		endcase

		// one bus phase: set up data with E high, or drop E
		if (do_ph) begin
			if (!en_q) begin
				if (cfg.bus_four_bit) begin
					data_n = {(hin_q ? ph_byte[7:4] : ph_byte[3:0]), 4'd0};
					hin_n  = !hin_q;
				end else begin
					data_n = ph_byte;
				end
				rs_n = ph_rs;
				en_n = 1'b1;
			end else begin
				en_n = 1'b0;
			end
		end
	end

	always_comb begin
		res.status = status_n;
		res.busy   = (mode_n == clcd_seq_pkg::MODE_INIT) || (req_n != clcd_seq_pkg::REQ_NONE);
		res.ready  = (mode_n == clcd_seq_pkg::MODE_OPER);
		res.rs     = rs_n;
		res.en     = en_n;
		res.data   = data_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= clcd_seq_pkg::MODE_OFF;
			init_q  <= clcd_seq_pkg::INIT_ARM;
			req_q   <= clcd_seq_pkg::REQ_NONE;
			rstep_q <= clcd_seq_pkg::RSTEP_START;
			en_q    <= 1'b0;
			hin_q   <= 1'b1;
			left_q  <= '0;
			wlen_q  <= '0;
			row_q   <= 1'b0;
			col_q   <= 4'd0;
			rs_q    <= 1'b0;
			data_q  <= 8'd0;
		end else if (fire) begin
			mode_q  <= mode_n;
			init_q  <= init_n;
			req_q   <= req_n;
			rstep_q <= rstep_n;
			en_q    <= en_n;
			hin_q   <= hin_n;
			left_q  <= left_n;
			wlen_q  <= wlen_n;
			row_q   <= row_n;
			col_q   <= col_n;
			rs_q    <= rs_n;
			data_q  <= data_n;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we)
			store_q[item.char_index[AW-1:0]] <= item.char_code;
	end

endmodule

/* rtl/char_lcd_parallel_sequencer_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_parallel_sequencer_core
// An accepted word goes through the input register, then the result register.
// Throughput: one word per cycle while res_stall does not hold the result register.
// Reset clears the sequencer state, valids and config registers; buffer is unset.
// ----------------------------------------------------------------------------
`include "char_lcd_parallel_sequencer_core_macros.svh"

module char_lcd_parallel_sequencer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [clcd_seq_pkg::ADDR_W-1:0]  paddr,
	input  logic [clcd_seq_pkg::DATA_W-1:0]  pwdata,
	output logic [clcd_seq_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [2:0]                       action,
	input  logic [1:0]                       row,
	input  logic [4:0]                       column,
	input  logic [clcd_seq_pkg::LEN_W-1:0]   length,
	input  logic [4:0]                       char_index,
	input  logic [7:0]                       char_code,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [1:0]                       status,
	output logic                             busy_res,
	output logic                             ready_res,
	output logic                             reg_select,
	output logic                             read_write,
	output logic                             enable_pin,
	output logic [7:0]                       data_bus
);

	clcd_seq_pkg::cfg_t  cfg;
	clcd_seq_pkg::item_t item_s1;
	clcd_seq_pkg::res_t  res;
	clcd_seq_pkg::res_t  res_s2;
	logic                valid_s1;
	logic                res_valid_q;
	logic                fire;
	logic                held_s1;
	logic                wr_unready;

	clcd_seq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	clcd_seq_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign fire       = valid_s1 && !(res_valid_q && res_stall);
	assign item_stall = valid_s1 && res_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!item_stall)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.action     <= action;
			item_s1.row        <= row;
			item_s1.column     <= column;
			item_s1.length     <= length;
			item_s1.char_index <= char_index;
			item_s1.char_code  <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fire)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_s2 <= res;
	end

	assign res_valid  = res_valid_q;
	assign status     = res_s2.status;
	assign busy_res   = res_s2.busy;
	assign ready_res  = res_s2.ready;
	assign reg_select = res_s2.rs;
	assign read_write = 1'b0;
	assign enable_pin = res_s2.en;
	assign data_bus   = res_s2.data;

	assign held_s1    = valid_s1 && item_stall;
	assign wr_unready = fire && (item_s1.action == clcd_seq_pkg::ACT_WRITE) && !res.ready;

	`CLCD_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, res_valid_q)
	`CLCD_ASSERT_NEXT(a_held_item_kept, clk, arst_n, held_s1, valid_s1 && $stable(item_s1))
	`CLCD_ASSERT_NOW(a_write_unready_err, clk, arst_n, wr_unready, res.status != 2'd0)

endmodule

/* test/char_lcd_parallel_sequencer_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_parallel_sequencer_core_checker
// Watches the register port and both word channels of the LCD sequencer,
// keeps its own copy of the sequencer state and registers, predicts the
// status and pin levels of every accepted word and compares the result words
// field by field in order. Hands the mismatch count and the number of
// outstanding result words to the testbench top.
// ----------------------------------------------------------------------------
module char_lcd_parallel_sequencer_core_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [clcd_seq_pkg::ADDR_W-1:0]  paddr,
	input  logic [clcd_seq_pkg::DATA_W-1:0]  pwdata,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  logic [2:0]                       action,
	input  logic [1:0]                       row,
	input  logic [4:0]                       column,
	input  logic [clcd_seq_pkg::LEN_W-1:0]   length,
	input  logic [4:0]                       char_index,
	input  logic [7:0]                       char_code,
	input  logic                             res_valid,
	input  logic                             res_stall,
	input  logic [1:0]                       status,
	input  logic                             busy_res,
	input  logic                             ready_res,
	input  logic                             reg_select,
	input  logic                             read_write,
	input  logic                             enable_pin,
	input  logic [7:0]                       data_bus,
	output int                               fail_count,
	output int                               due_count
);

	import clcd_seq_pkg::*;

	logic       four_bit;
	logic [7:0] first_fs;
	logic [7:0] fs_cmd;
	logic [7:0] disp_cmd;
	logic [7:0] clr_cmd;
	logic [7:0] entry_cmd;
	logic [7:0] home_cmd;

	mode_t      mode;
	init_t      istep;
	req_t       req;
	rstep_t     rstep;
	logic       e_lvl;
	logic       hi_next;
	logic [5:0] left;
	logic [5:0] wlen;
	logic       trow;
	logic [3:0] tcol;
	logic [9:0] latch;
	logic [7:0] chars [BUF_DEPTH];

	res_t       due_levels [$];

	function automatic bit drive_phase(input logic [7:0] b, input logic rs);
		logic [7:0] d;
		if (!e_lvl) begin
			if (four_bit) begin
				d = {(hi_next ? b[7:4] : b[3:0]), 4'h0};
				hi_next = !hi_next;
			end else begin
				d = b;
			end
			latch = {rs, 1'b0, d};
			e_lvl = 1'b1;
			return 1'b0;
		end
		e_lvl = 1'b0;
		return four_bit ? hi_next : 1'b1;
	endfunction

	task automatic init_phase();
		logic [7:0] b;
		case (istep)
			INIT_ARM: begin
				e_lvl = 1'b0;
				istep = INIT_FS1;
				return;
			end
			INIT_FS1:   b = four_bit ? first_fs : fs_cmd;
			INIT_FS2:   b = fs_cmd;
			INIT_DISP:  b = disp_cmd;
			INIT_CLR:   b = clr_cmd;
			INIT_ENTRY: b = entry_cmd;
			INIT_HOME:  b = home_cmd;
			default: begin
				mode = MODE_OPER;
				return;
			end
		endcase
		if (drive_phase(b, 1'b0))
			istep = (istep == INIT_FS1 && !four_bit) ? INIT_DISP : init_t'(istep + 1);
	endtask

	task automatic write_phase();
		logic [7:0] pos;
		logic [5:0] idx;
		logic       lownib;
		case (rstep)
			RSTEP_START: begin
				e_lvl = 1'b0;
				rstep = RSTEP_CMD;
			end
			RSTEP_CMD: begin
				pos = POS_CMD_BASE + {4'h0, tcol} + (trow ? ROW1_OFFSET : 8'h00);
				if (drive_phase(pos, 1'b0))
					rstep = RSTEP_DATA;
			end
			RSTEP_DATA: begin
				if (left == 0) begin
					rstep = RSTEP_END;
					e_lvl = 1'b0;
				end else if (e_lvl) begin
					e_lvl = 1'b0;
					if (!four_bit)
						left--;
				end else begin
					idx = wlen - left;
					lownib = four_bit && !hi_next;
					void'(drive_phase(chars[idx[4:0]], 1'b1));
					if (lownib)
						left--;
				end
			end
			default: begin
				req = REQ_NONE;
				rstep = RSTEP_START;
			end
		endcase
	endtask

	task automatic clear_phase();
		case (rstep)
			RSTEP_START: begin
				e_lvl = 1'b0;
				rstep = RSTEP_CMD;
			end
			RSTEP_CMD: begin
				if (drive_phase(clr_cmd, 1'b0))
					rstep = RSTEP_DATA;
			end
			default: begin
				req = REQ_NONE;
				rstep = RSTEP_START;
			end
		endcase
	endtask

	task automatic advance_sequencer(input logic [2:0] act, input logic [1:0] r,
			input logic [4:0] c, input logic [5:0] n, input logic [4:0] ix,
			input logic [7:0] code);
		status_t st;
		logic    free_now;
		res_t    lv;
		st = ST_OK;
		free_now = (mode == MODE_OPER) && (req == REQ_NONE);
		case (act)
			ACT_TICK: begin
				if (mode == MODE_INIT)
					init_phase();
				else if (mode == MODE_OPER && req == REQ_WRITE)
					write_phase();
				else if (mode == MODE_OPER && req == REQ_CLEAR)
					clear_phase();
			end
			ACT_START: begin
				mode = MODE_INIT;
				istep = INIT_ARM;
				req = REQ_NONE;
				rstep = RSTEP_START;
				e_lvl = 1'b0;
				hi_next = 1'b1;
			end
			ACT_WRITE: begin
				if (r > 1)
					st = ST_ROW_ERR;
				else if (c > 15)
					st = ST_COL_ERR;
				else if (!free_now)
					st = ST_NOT_READY;
				else begin
					trow = r[0];
					tcol = c[3:0];
					wlen = (n > BUF_DEPTH) ? 6'(BUF_DEPTH) : n;
					left = wlen;
					req = REQ_WRITE;
					rstep = RSTEP_START;
				end
			end
			ACT_CLEAR: begin
				if (!free_now)
					st = ST_NOT_READY;
				else begin
					req = REQ_CLEAR;
					rstep = RSTEP_START;
				end
			end
			ACT_LOAD: chars[ix] = code;
			default: ;
		endcase
		lv.status = st;
		lv.busy = (mode == MODE_INIT) || (req != REQ_NONE);
		lv.ready = (mode == MODE_OPER);
		lv.rs = latch[9];
		lv.en = e_lvl;
		lv.data = latch[7:0];
		due_levels.push_back(lv);
	endtask

	task automatic check_field(input string tag, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, tag, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			four_bit = 1'b0;
			first_fs = 8'd50;
			fs_cmd = 8'd56;
			disp_cmd = 8'd12;
			clr_cmd = 8'd1;
			entry_cmd = 8'd6;
			home_cmd = 8'd128;
			mode = MODE_OFF;
			istep = INIT_ARM;
			req = REQ_NONE;
			rstep = RSTEP_START;
			e_lvl = 1'b0;
			hi_next = 1'b1;
			left = '0;
			wlen = '0;
			trow = 1'b0;
			tcol = '0;
			latch = '0;
			due_levels.delete();
			fail_count = 0;
			due_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_BUS_FOUR_BIT: four_bit = pwdata[0];
					REG_FIRST_FS:     first_fs = pwdata[7:0];
					REG_FUNCTION_SET: fs_cmd = pwdata[7:0];
					REG_DISPLAY_CTRL: disp_cmd = pwdata[7:0];
					REG_CLEAR:        clr_cmd = pwdata[7:0];
					REG_ENTRY_MODE:   entry_cmd = pwdata[7:0];
					REG_HOME_ADDRESS: home_cmd = pwdata[7:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (due_levels.size() == 0) begin
					fail_count++;
					$display("%0t ns: result word with none expected, status %0h data %0h",
						$time, status, data_bus);
				end else begin
					want = due_levels.pop_front();
					check_field("status", want.status, status);
					check_field("busy_res", want.busy, busy_res);
					check_field("ready_res", want.ready, ready_res);
					check_field("reg_select", want.rs, reg_select);
					check_field("read_write", 1'b0, read_write);
					check_field("enable_pin", want.en, enable_pin);
					check_field("data_bus", want.data, data_bus);
				end
			end
			if (item_valid && !item_stall)
				advance_sequencer(action, row, column, length, char_index, char_code);
			due_count <= due_levels.size();
		end
	end

endmodule

/* test/char_lcd_parallel_sequencer_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_parallel_sequencer_core_tb
// Drives the LCD sequencer with a directed run through reset defaults, errors,
// init, writes, clears and restarts, then random phases of init, write, clear
// and load sequences mixed with noise under several register settings and
// idle/stall patterns. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module char_lcd_parallel_sequencer_core_tb;

	import clcd_seq_pkg::*;

	localparam logic [2:0] ACT_SPARE   = 3'd7;
	localparam int         QUIET_LIMIT = 4000;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [2:0]          action = ACT_TICK;
	logic [1:0]          row = '0;
	logic [4:0]          column = '0;
	logic [LEN_W-1:0]    length = '0;
	logic [4:0]          char_index = '0;
	logic [7:0]          char_code = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [1:0]          status;
	logic                busy_res;
	logic                ready_res;
	logic                reg_select;
	logic                read_write;
	logic                enable_pin;
	logic [7:0]          data_bus;

	int                  fail_count;
	int                  due_count;
	int                  tx_pct = 0;
	int                  rx_pct = 0;
	int                  sent = 0;
	int                  quiet_cycles = 0;
	logic                four_bit_sh = 1'b0;
	bit                  loaded [BUF_DEPTH];

	always #2 clk = ~clk;

	char_lcd_parallel_sequencer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.action(action), .row(row), .column(column), .length(length),
		.char_index(char_index), .char_code(char_code),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .busy_res(busy_res), .ready_res(ready_res),
		.reg_select(reg_select), .read_write(read_write),
		.enable_pin(enable_pin), .data_bus(data_bus)
	);

	char_lcd_parallel_sequencer_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.item_valid(item_valid), .item_stall(item_stall),
		.action(action), .row(row), .column(column), .length(length),
		.char_index(char_index), .char_code(char_code),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .busy_res(busy_res), .ready_res(ready_res),
		.reg_select(reg_select), .read_write(read_write),
		.enable_pin(enable_pin), .data_bus(data_bus),
		.fail_count(fail_count), .due_count(due_count)
	);

	always @(posedge clk)
		res_stall <= ($urandom_range(0, 99) < rx_pct);

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("char_lcd_parallel_sequencer_core verification failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic int loaded_run();
		int k;
		k = 0;
		while (k < BUF_DEPTH && loaded[k])
			k++;
		return k;
	endfunction

	task automatic send_word(input logic [2:0] a, input logic [1:0] r, input logic [4:0] c,
			input logic [5:0] n, input logic [4:0] ix, input logic [7:0] code);
		int lead;
		lead = loaded_run();
		// keep accepted writes inside the loaded part of the buffer
		if (a == ACT_WRITE && r < 2 && c < 16 && ((n > BUF_DEPTH) ? BUF_DEPTH : n) > lead)
			n = 6'(lead);
		if (a == ACT_LOAD)
			loaded[ix] = 1'b1;
		while ($urandom_range(0, 99) < tx_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= a;
		row <= r;
		column <= c;
		length <= n;
		char_index <= ix;
		char_code <= code;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic tick_n(input int k);
		repeat (k)
			send_word(ACT_TICK, 2'($urandom), 5'($urandom), 6'($urandom), 5'($urandom),
				8'($urandom));
	endtask

	task automatic restart_init(input bit cut_short);
		int n;
		n = (four_bit_sh ? 6 : 5) * (four_bit_sh ? 4 : 2) + 2;
		send_word(ACT_START, 2'($urandom), 5'($urandom), 6'($urandom), 5'($urandom),
			8'($urandom));
		tick_n(cut_short ? $urandom_range(0, n - 1) : n + $urandom_range(0, 2));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic program_regs(input logic four, input fill_t fill);
		logic [31:0] v;
		drain();
		for (int i = REG_FIRST_FS; i <= REG_HOME_ADDRESS; i++) begin
			v = (fill == FILL_ZERO) ? 32'h0 : (fill == FILL_ONES) ? 32'hFFFF_FFFF : $urandom;
			reg_write(3'(i), v);
		end
		v = $urandom;
		reg_write(REG_BUS_FOUR_BIT, {v[31:1], four});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		four_bit_sh = four;
	endtask

	task automatic run_phase(input int words, input int tx, input int rx);
		int         stop_at;
		int         lead;
		int         n;
		int         cost;
		logic [2:0] a;
		logic [1:0] r;
		logic [4:0] c;
		logic [5:0] len;
		tx_pct = tx;
		rx_pct = rx;
		stop_at = sent + words;
		cost = four_bit_sh ? 4 : 2;
		restart_init(1'b0);
		while (sent < stop_at) begin
			lead = loaded_run();
			case ($urandom_range(0, 19))
				0: restart_init($urandom_range(0, 3) == 0);
				1, 2, 3, 4, 5, 6: begin
					r = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
						: 2'($urandom_range(0, 1));
					c = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
						: 5'($urandom_range(0, 15));
					if (lead == BUF_DEPTH && $urandom_range(0, 7) == 0)
						len = 6'($urandom_range(BUF_DEPTH, (1 << LEN_W) - 1));
					else
						len = 6'($urandom_range(0, (lead < 8) ? lead : 8));
					n = 3 + cost * (((len > BUF_DEPTH) ? BUF_DEPTH : len) + 1);
					send_word(ACT_WRITE, r, c, len, 5'($urandom), 8'($urandom));
					tick_n(($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n);
				end
				7, 8: begin
					send_word(ACT_CLEAR, 2'($urandom), 5'($urandom), 6'($urandom),
						5'($urandom), 8'($urandom));
					tick_n(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
						: 3 + cost + $urandom_range(0, 1));
				end
				9, 10, 11: begin
					repeat ($urandom_range(1, 4)) begin
						lead = loaded_run();
						send_word(ACT_LOAD, 2'($urandom), 5'($urandom), 6'($urandom),
							(lead < BUF_DEPTH) ? 5'(lead) : 5'($urandom), 8'($urandom));
					end
				end
				12: drain();
				default: begin
					a = 3'($urandom);
					if (a == ACT_START)
						a = ACT_TICK;
					send_word(a, 2'($urandom), 5'($urandom), 6'($urandom), 5'($urandom),
						8'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_WRITE, 2'd0, 5'd0, 6'd0, 5'd0, 8'h00);
		send_word(ACT_CLEAR, 2'd3, 5'd31, 6'd63, 5'd31, 8'hFF);
		send_word(ACT_TICK, 2'd0, 5'd0, 6'd0, 5'd0, 8'h00);
		send_word(ACT_SPARE, 2'd3, 5'd31, 6'd63, 5'd31, 8'hFF);
		send_word(ACT_LOAD, 2'd0, 5'd0, 6'd0, 5'd0, 8'hFF);
		send_word(ACT_LOAD, 2'd0, 5'd0, 6'd0, 5'd1, 8'h00);
		send_word(ACT_LOAD, 2'd0, 5'd0, 6'd0, 5'd2, 8'h81);
		send_word(ACT_LOAD, 2'd0, 5'd0, 6'd0, 5'd31, 8'h7E);
		restart_init(1'b0);
		send_word(ACT_WRITE, 2'd3, 5'd31, 6'd63, 5'd0, 8'h00);
		send_word(ACT_WRITE, 2'd1, 5'd16, 6'd1, 5'd0, 8'h00);
		send_word(ACT_WRITE, 2'd1, 5'd15, 6'd3, 5'd0, 8'h00);
		send_word(ACT_CLEAR, 2'd0, 5'd0, 6'd0, 5'd0, 8'h00);
		tick_n(11);
		send_word(ACT_CLEAR, 2'd0, 5'd0, 6'd0, 5'd0, 8'h00);
		tick_n(5);
		send_word(ACT_WRITE, 2'd0, 5'd0, 6'd0, 5'd0, 8'h00);
		tick_n(5);
		send_word(ACT_WRITE, 2'd0, 5'd3, 6'd2, 5'd0, 8'h00);
		tick_n(3);
		restart_init(1'b0);

		program_regs(1'b1, FILL_ONES);
		run_phase(400, 0, 0);
		program_regs(1'b0, FILL_ZERO);
		run_phase(400, 80, 0);
		program_regs(1'b1, FILL_RAND);
		run_phase(400, 0, 80);
		program_regs(1'b0, FILL_RAND);
		run_phase(400, 24, 24);

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("char_lcd_parallel_sequencer_core verification clean");
		else
			$display("char_lcd_parallel_sequencer_core verification failed");
		$finish;
	end

endmodule
